[hw/rtl/thcr_pkg.sv]
// thcr_pkg: shared widths, request codes and the controller/datapath
// command and status structs of the two-hop conflict row block.
// No dependencies.
package thcr_pkg;

	// field widths fixed by the interface
	localparam int ROW_W  = 32;
	localparam int CH_W   = 4;
	localparam int NODE_W = 5;
	localparam int CFG_W  = 6;

	// num_nodes after reset
	localparam logic [CFG_W-1:0] NUM_NODES_RST = 6'd32;

	// req_type codes
	localparam logic REQ_WRITE = 1'b0;
	localparam logic REQ_QUERY = 1'b1;

	// controller -> datapath
	typedef struct packed {
		logic clr_step;   // write one zero row of the clearing sweep
		logic wr_row;     // store the accepted write word
		logic q_start;    // capture the accepted query word
		logic rd_own;     // read the queried node's own row
		logic ld_direct;  // latch the own row as direct set, reset scan
		logic scan_step;  // examine one neighbor, read its row if needed
		logic finish;     // load the result word into the output register
	} thcr_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic clr_done;   // sweep is at the last row
		logic q_bad;      // query on a bad channel or an inactive node
		logic scan_last;  // neighbor index is the last active node
		logic out_free;   // output register can take a word this cycle
	} thcr_stat_t;

endpackage

[hw/rtl/two_hop_conflict_rows.sv]
// two_hop_conflict_rows: top level joining the controller and the datapath.
// Depends on thcr_pkg, thcr_ctrl, thcr_datapath.
//
// Input channel (in_valid/in_ready) takes one word per item: req_type
// selects a row write (row_bits stored at channel/node) or a query.
// A write produces no output word.
// A query reads the node's own row, then steps over every active node
// index k, one per cycle, reading row k when the direct row has bit k
// set; the active node count is num_nodes capped at 32. A query on a
// bad channel or an inactive node skips the reads and answers zero. The
// single read port of the row memory sets this pace: one row per cycle.
// Output channel (out_valid/out_ready) holds the result in a register;
// the next input word is taken while a result waits, and a query only
// stalls in its last step if the previous result is still not taken.
// Config channel (cfg_valid/cfg_ready) writes num_nodes; always ready.
// After reset the block sweeps zeros through all rows of the memory,
// CHANNEL_COUNT x NODE_COUNT_MAX rounded up to powers of two (512 rows
// at the defaults), with in_ready low; num_nodes resets to 32.
module two_hop_conflict_rows
	import thcr_pkg::*;
#(
	parameter int NODE_COUNT_MAX = 32,
	parameter int CHANNEL_COUNT  = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              req_type,
	input  logic [CH_W-1:0]   channel,
	input  logic [NODE_W-1:0] node,
	input  logic [ROW_W-1:0]  row_bits,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [ROW_W-1:0]  conflict_bits,
	output logic [NODE_W-1:0] queried_node,
	output logic [CH_W-1:0]   queried_channel,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [CFG_W-1:0]  num_nodes
);

	thcr_cmd_t  cmd;
	thcr_stat_t stat;

	assign cfg_ready = 1'b1;

	thcr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.req_type (req_type),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	thcr_datapath #(
		.NODE_COUNT_MAX (NODE_COUNT_MAX),
		.CHANNEL_COUNT  (CHANNEL_COUNT)
	) u_datapath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.stat            (stat),
		.cfg_wr          (cfg_valid && cfg_ready),
		.num_nodes       (num_nodes),
		.channel         (channel),
		.node            (node),
		.row_bits        (row_bits),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.conflict_bits   (conflict_bits),
		.queried_node    (queried_node),
		.queried_channel (queried_channel)
	);

endmodule

[hw/rtl/thcr_ctrl.sv]
// thcr_ctrl: sequencer for clearing, row writes and two-hop queries.
// Depends on thcr_pkg (command/status structs, request codes).
module thcr_ctrl
	import thcr_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       req_type,
	output logic       in_ready,
	input  thcr_stat_t stat,
	output thcr_cmd_t  cmd
);

	localparam logic [2:0] ST_CLEAR  = 3'd0;
	localparam logic [2:0] ST_IDLE   = 3'd1;
	localparam logic [2:0] ST_OWN    = 3'd2;
	localparam logic [2:0] ST_DIRECT = 3'd3;
	localparam logic [2:0] ST_SCAN   = 3'd4;
	localparam logic [2:0] ST_DRAIN  = 3'd5;
	localparam logic [2:0] ST_FINISH = 3'd6;

	logic [2:0] state_q;
	logic [2:0] state_nxt;
	logic       accept;

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;

	// next state and commands
	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		case (state_q)
			ST_CLEAR: begin
				cmd.clr_step = 1'b1;
				if (stat.clr_done) state_nxt = ST_IDLE;
			end
			ST_IDLE: begin
				if (accept) begin
					if (req_type == REQ_QUERY) begin
						cmd.q_start = 1'b1;
						state_nxt   = ST_OWN;
					end else begin
						cmd.wr_row = 1'b1;
					end
				end
			end
			ST_OWN: begin
				// bad queries skip the reads and answer zero
				if (stat.q_bad) begin
					state_nxt = ST_FINISH;
				end else begin
					cmd.rd_own = 1'b1;
					state_nxt  = ST_DIRECT;
				end
			end
			ST_DIRECT: begin
				cmd.ld_direct = 1'b1;
				state_nxt     = ST_SCAN;
			end
			ST_SCAN: begin
				cmd.scan_step = 1'b1;
				if (stat.scan_last) state_nxt = ST_DRAIN;
			end
			ST_DRAIN: begin
				// last neighbor row lands this cycle
				state_nxt = ST_FINISH;
			end
			ST_FINISH: begin
				if (stat.out_free) begin
					cmd.finish = 1'b1;
					state_nxt  = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_CLEAR;
		else         state_q <= state_nxt;
	end

endmodule

[hw/rtl/thcr_datapath.sv]
// thcr_datapath: row memory, clearing sweep, neighbor scan, result
// accumulation and output register. Depends on thcr_pkg.
module thcr_datapath
	import thcr_pkg::*;
#(
	parameter int NODE_COUNT_MAX = 32,
	parameter int CHANNEL_COUNT  = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  thcr_cmd_t         cmd,
	output thcr_stat_t        stat,
	input  logic              cfg_wr,
	input  logic [CFG_W-1:0]  num_nodes,
	input  logic [CH_W-1:0]   channel,
	input  logic [NODE_W-1:0] node,
	input  logic [ROW_W-1:0]  row_bits,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [ROW_W-1:0]  conflict_bits,
	output logic [NODE_W-1:0] queried_node,
	output logic [CH_W-1:0]   queried_channel
);

	localparam int NODE_AW  = (NODE_COUNT_MAX > 1) ? $clog2(NODE_COUNT_MAX) : 1;
	localparam int CH_AW    = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;
	localparam int ADDR_W   = CH_AW + NODE_AW;
	localparam int DEPTH    = 1 << ADDR_W;
	localparam int NODE_LIM = (NODE_COUNT_MAX < ROW_W) ? NODE_COUNT_MAX : ROW_W;

	logic [ROW_W-1:0]  mem [DEPTH];
	logic [ROW_W-1:0]  rd_data_q;
	logic [ADDR_W-1:0] clr_addr_q;
	logic [CFG_W-1:0]  num_nodes_q;
	logic [CH_W-1:0]   ch_q;
	logic [NODE_W-1:0] node_q;
	logic [NODE_W-1:0] k_q;
	logic [ROW_W-1:0]  direct_q;
	logic [ROW_W-1:0]  acc_q;
	logic              hop_pend_q;
	logic              out_valid_q;
	logic [ROW_W-1:0]  conflict_q;
	logic [NODE_W-1:0] qnode_q;
	logic [CH_W-1:0]   qch_q;

	logic [CFG_W-1:0]      n_act;
	logic [ROW_W-1:0]      mask;
	logic [CH_AW+CH_W-1:0] in_ch_w;
	logic [CH_AW+CH_W-1:0] q_ch_w;
	logic [NODE_AW+NODE_W-1:0] in_nd_w;
	logic [NODE_AW+NODE_W-1:0] q_nd_w;
	logic [NODE_AW+NODE_W-1:0] k_w;
	logic [ADDR_W-1:0]     wr_addr;
	logic [ADDR_W-1:0]     rd_addr;
	logic                  wr_in_range;
	logic                  wr_en;
	logic                  hop_issue;

	// active node count and its bit mask
	assign n_act = (num_nodes_q > CFG_W'(NODE_LIM)) ? CFG_W'(NODE_LIM) : num_nodes_q;
	assign mask  = n_act[CFG_W-1] ? '1 : ((ROW_W'(1) << n_act[CFG_W-2:0]) - ROW_W'(1));

	// row addresses: channel above node
	assign in_ch_w = {CH_AW'(0), channel};
	assign q_ch_w  = {CH_AW'(0), ch_q};
	assign in_nd_w = {NODE_AW'(0), node};
	assign q_nd_w  = {NODE_AW'(0), node_q};
	assign k_w     = {NODE_AW'(0), k_q};

	assign wr_in_range = ({1'b0, channel} < (CH_W + 1)'(CHANNEL_COUNT)) &&
	                     ({2'b0, node} < (NODE_W + 2)'(NODE_COUNT_MAX));
	assign wr_en   = cmd.clr_step || (cmd.wr_row && wr_in_range);
	assign wr_addr = cmd.clr_step ? clr_addr_q
	                              : {in_ch_w[CH_AW-1:0], in_nd_w[NODE_AW-1:0]};
	assign rd_addr = cmd.rd_own ? {q_ch_w[CH_AW-1:0], q_nd_w[NODE_AW-1:0]}
	                            : {q_ch_w[CH_AW-1:0], k_w[NODE_AW-1:0]};

	// a neighbor row is read only for set direct bits other than self
	assign hop_issue = cmd.scan_step && direct_q[k_q] && (k_q != node_q);

	// status
	assign stat.clr_done  = (clr_addr_q == '1);
	assign stat.q_bad     = ({1'b0, ch_q} >= (CH_W + 1)'(CHANNEL_COUNT)) ||
	                        ({1'b0, node_q} >= n_act);
	assign stat.scan_last = ({1'b0, k_q} == (n_act - CFG_W'(1)));
	assign stat.out_free  = !out_valid_q || out_ready;

	// row memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= cmd.clr_step ? '0 : row_bits;
		rd_data_q <= mem[rd_addr];
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q  <= '0;
			num_nodes_q <= NUM_NODES_RST;
			hop_pend_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.clr_step) clr_addr_q <= clr_addr_q + ADDR_W'(1);
			if (cfg_wr)       num_nodes_q <= num_nodes;
			hop_pend_q <= hop_issue;
			if (cmd.finish)     out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	// query capture, neighbor scan and accumulation
	always_ff @(posedge clk) begin
		if (cmd.q_start) begin
			ch_q   <= channel;
			node_q <= node;
		end
		if (cmd.ld_direct) begin
			direct_q <= rd_data_q & mask;
			acc_q    <= rd_data_q & mask;
			k_q      <= '0;
		end else begin
			if (cmd.scan_step) k_q <= k_q + NODE_W'(1);
			if (hop_pend_q)    acc_q <= acc_q | (rd_data_q & mask);
		end
	end

	// output word
	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			conflict_q <= stat.q_bad ? '0 : (acc_q & ~(ROW_W'(1) << node_q));
			qnode_q    <= node_q;
			qch_q      <= ch_q;
		end
	end

	assign out_valid       = out_valid_q;
	assign conflict_bits   = conflict_q;
	assign queried_node    = qnode_q;
	assign queried_channel = qch_q;

endmodule

[hw/rtl/thcr_checker.sv]
// thcr_checker: port-level assertions for two_hop_conflict_rows, and the
// bind that attaches them. Depends on thcr_pkg.
module thcr_checker
	import thcr_pkg::*;
#(
	parameter int CHANNEL_COUNT = 16
) (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_ready,
	input logic              req_type,
	input logic              out_valid,
	input logic              out_ready,
	input logic [ROW_W-1:0]  conflict_bits,
	input logic [NODE_W-1:0] queried_node,
	input logic [CH_W-1:0]   queried_channel
);

	// stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(conflict_bits) &&
		$stable(queried_node) && $stable(queried_channel))
		else $error("result word changed while stalled");

	// the queried node never conflicts with itself
	a_self_clear: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (conflict_bits[queried_node] == 1'b0))
		else $error("self bit set in conflict row");

	// a query on a channel out of range answers zero
	a_bad_channel: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && ({1'b0, queried_channel} >= (CH_W + 1)'(CHANNEL_COUNT))
		|-> (conflict_bits == '0))
		else $error("nonzero row for channel out of range");

	// a row write never makes a result word appear right after it
	a_write_silent: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (req_type == REQ_WRITE) |=> !$rose(out_valid))
		else $error("result word raised by a row write");

endmodule

bind two_hop_conflict_rows thcr_checker #(
	.CHANNEL_COUNT (CHANNEL_COUNT)
) u_thcr_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.in_valid        (in_valid),
	.in_ready        (in_ready),
	.req_type        (req_type),
	.out_valid       (out_valid),
	.out_ready       (out_ready),
	.conflict_bits   (conflict_bits),
	.queried_node    (queried_node),
	.queried_channel (queried_channel)
);

[dv/two_hop_conflict_rows_tb.sv]
// two_hop_conflict_rows_tb: self-checking bench for the two-hop conflict row block.
// It drives write and query words, predicts every conflict row and checks each result.
// Depends on thcr_pkg and two_hop_conflict_rows.
module two_hop_conflict_rows_tb;
	import thcr_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int CH_COUNT     = 16;
	localparam int NODE_MAX     = 32;
	localparam int DRAIN_CYCLES = 48;    // a full query at 32 nodes plus slack
	localparam int STALL_LIMIT  = 4000;  // covers the clearing sweep after reset

	// one input word as sent to the block
	typedef struct {
		logic              req;
		logic [CH_W-1:0]   ch;
		logic [NODE_W-1:0] nd;
		logic [ROW_W-1:0]  bits;
	} req_word_t;

	// one expected conflict row
	typedef struct {
		logic [ROW_W-1:0]  row;
		logic [NODE_W-1:0] nd;
		logic [CH_W-1:0]   ch;
	} conflict_word_t;

	logic              clk       = 1'b0;
	logic              arst_n    = 1'b0;
	logic              in_valid  = 1'b0;
	logic              in_ready;
	logic              req_type  = REQ_WRITE;
	logic [CH_W-1:0]   channel   = '0;
	logic [NODE_W-1:0] node      = '0;
	logic [ROW_W-1:0]  row_bits  = '0;
	logic              out_valid;
	logic              out_ready = 1'b0;
	logic [ROW_W-1:0]  conflict_bits;
	logic [NODE_W-1:0] queried_node;
	logic [CH_W-1:0]   queried_channel;
	logic              cfg_valid = 1'b0;
	logic              cfg_ready;
	logic [CFG_W-1:0]  num_nodes = NUM_NODES_RST;

	// predictor state: interference rows and the active node setting
	logic [ROW_W-1:0] intf_rows [CH_COUNT][NODE_MAX];
	logic [CFG_W-1:0] nodes_cfg = NUM_NODES_RST;

	req_word_t      pending_words[$];
	conflict_word_t conflict_q[$];
	req_word_t      held_word;
	int             words_queued  = 0;
	int             words_sent    = 0;
	int             mismatch_cnt  = 0;
	int             stall_cycles  = 0;
	int             send_idle_pct = 0;
	int             recv_idle_pct = 0;

	two_hop_conflict_rows u_top (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.req_type        (req_type),
		.channel         (channel),
		.node            (node),
		.row_bits        (row_bits),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.conflict_bits   (conflict_bits),
		.queried_node    (queried_node),
		.queried_channel (queried_channel),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.num_nodes       (num_nodes)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// clear predicted rows at time zero, matching the sweep after reset
	initial begin
		foreach (intf_rows[c, n])
			intf_rows[c][n] = '0;
	end

	// two-hop conflict row of node nd on channel ch under the current setting
	function automatic logic [ROW_W-1:0] conflict_row(logic [CH_W-1:0] ch,
			logic [NODE_W-1:0] nd);
		int               n;
		int               k;
		logic [ROW_W-1:0] mask;
		logic [ROW_W-1:0] direct;
		logic [ROW_W-1:0] acc;
		n = (nodes_cfg > NODE_MAX) ? NODE_MAX : int'(nodes_cfg);
		mask = (n >= ROW_W) ? '1 : ((32'd1 << n) - 32'd1);
		if (int'(ch) >= CH_COUNT || int'(nd) >= n)
			return '0;
		direct = intf_rows[ch][nd] & mask;
		acc = direct;
		for (k = 0; k < n; k++) begin
			if (k != int'(nd) && direct[k])
				acc |= intf_rows[ch][k] & mask;
		end
		acc[nd] = 1'b0;
		return acc;
	endfunction

	// apply an accepted word: store the row, or queue the expected answer
	task automatic apply_word(req_word_t w);
		conflict_word_t e;
		if (w.req == REQ_WRITE) begin
			if (int'(w.ch) < CH_COUNT && int'(w.nd) < NODE_MAX)
				intf_rows[w.ch][w.nd] = w.bits;
		end else begin
			e.row = conflict_row(w.ch, w.nd);
			e.nd  = w.nd;
			e.ch  = w.ch;
			conflict_q.push_back(e);
		end
	endtask

	task automatic report_mismatch(string what, logic [ROW_W-1:0] got,
			logic [ROW_W-1:0] exp_val);
		$display("[%0t] MISMATCH %s: got %h expected %h", $realtime, what, got, exp_val);
		mismatch_cnt++;
	endtask

	// input driver: holds a word until it is taken, idles at random
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				apply_word(held_word);
				words_sent++;
			end
			if (!in_valid || in_ready) begin
				if (pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					held_word = pending_words.pop_front();
					in_valid <= 1'b1;
					req_type <= held_word.req;
					channel  <= held_word.ch;
					node     <= held_word.nd;
					row_bits <= held_word.bits;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// result monitor: compares each taken word with the oldest expectation
	always @(posedge clk or negedge arst_n) begin
		conflict_word_t e;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (conflict_q.size() == 0) begin
					report_mismatch("result with no query waiting", conflict_bits, '0);
				end else begin
					e = conflict_q.pop_front();
					if (conflict_bits !== e.row)
						report_mismatch("conflict_bits", conflict_bits, e.row);
					if (queried_node !== e.nd)
						report_mismatch("queried_node", 32'(queried_node), 32'(e.nd));
					if (queried_channel !== e.ch)
						report_mismatch("queried_channel", 32'(queried_channel), 32'(e.ch));
				end
			end
			out_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// watchdog: cycles in a row with no handshake on any channel
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
	end

	initial begin
		while (stall_cycles < STALL_LIMIT)
			@(posedge clk);
		$display("two_hop_conflict_rows regression: fail");
		$finish;
	end

	task automatic push_word(logic req, int ch, int nd, logic [ROW_W-1:0] bits);
		req_word_t w;
		w.req  = req;
		w.ch   = CH_W'(ch);
		w.nd   = NODE_W'(nd);
		w.bits = bits;
		pending_words.push_back(w);
		words_queued++;
	endtask

	// row content: empty, full, sparse or dense
	function automatic logic [ROW_W-1:0] rand_row();
		case ($urandom_range(9))
			0: return '0;
			1: return '1;
			2, 3, 4: return $urandom & $urandom & $urandom;
			default: return $urandom;
		endcase
	endfunction

	// random words, mostly on a few channels and on active nodes
	task automatic push_random(int count);
		int  i;
		int  n;
		int  ch;
		int  nd;
		logic req;
		n = (nodes_cfg > NODE_MAX) ? NODE_MAX : int'(nodes_cfg);
		for (i = 0; i < count; i++) begin
			req = ($urandom_range(99) < 45) ? REQ_WRITE : REQ_QUERY;
			ch = ($urandom_range(99) < 75) ? $urandom_range(3) : $urandom_range(15);
			if (n > 0 && $urandom_range(99) < 85)
				nd = $urandom_range(n - 1);
			else
				nd = $urandom_range(31);
			push_word(req, ch, nd, rand_row());
		end
	endtask

	// wait until every word is sent and answered, then let the block settle
	task automatic drain();
		while (words_sent != words_queued || conflict_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// write num_nodes while the block is idle
	task automatic write_nodes(logic [CFG_W-1:0] value);
		@(posedge clk);
		cfg_valid <= 1'b1;
		num_nodes <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		nodes_cfg = value;
		cfg_valid <= 1'b0;
	endtask

	task automatic set_idle(int send_pct, int recv_pct);
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// directed words at the reset setting of 32 nodes
		set_idle(10, 53);
		push_word(REQ_QUERY, 0, 0, '0);
		push_word(REQ_QUERY, 15, 31, '1);
		push_word(REQ_WRITE, 15, 31, '1);
		push_word(REQ_QUERY, 15, 31, '0);
		// chain 0 -> 1 -> {2, 31}, 2 -> 0
		push_word(REQ_WRITE, 0, 0, 32'h0000_0002);
		push_word(REQ_WRITE, 0, 1, 32'h8000_0004);
		push_word(REQ_WRITE, 0, 2, 32'h0000_0001);
		push_word(REQ_QUERY, 0, 0, 32'hFFFF_FFFF);
		push_word(REQ_QUERY, 0, 1, '0);
		push_word(REQ_QUERY, 0, 2, 32'h1234_5678);
		// own bit set in the row and reached back through a neighbor
		push_word(REQ_WRITE, 3, 5, 32'h0000_0060);
		push_word(REQ_WRITE, 3, 6, 32'h0000_0020);
		push_word(REQ_QUERY, 3, 5, '0);
		push_word(REQ_QUERY, 3, 6, '0);
		// alternating patterns
		push_word(REQ_WRITE, 7, 0, 32'hAAAA_5555);
		push_word(REQ_WRITE, 7, 1, 32'h5555_AAAA);
		push_word(REQ_QUERY, 7, 0, '1);
		push_word(REQ_QUERY, 7, 1, '0);
		// overwrite with empty rows
		push_word(REQ_WRITE, 0, 1, '0);
		push_word(REQ_QUERY, 0, 0, '0);
		push_word(REQ_WRITE, 15, 31, '0);
		push_word(REQ_QUERY, 15, 31, 32'hFFFF_FFFF);
		drain();

		// sender idles lightly, receiver heavily
		write_nodes(6'd32);
		push_random(150);
		drain();
		write_nodes(6'd1);
		push_random(100);
		drain();

		// receiver idles lightly, sender heavily
		set_idle(53, 10);
		write_nodes(6'd63);
		push_random(150);
		drain();
		write_nodes(6'd0);
		push_random(80);
		drain();
		write_nodes(6'd5);
		push_random(150);
		drain();

		// no idling on either side
		set_idle(0, 0);
		write_nodes(CFG_W'($urandom_range(31, 2)));
		push_random(150);
		drain();
		write_nodes(6'd32);
		push_random(250);
		drain();

		if (mismatch_cnt == 0 && conflict_q.size() == 0)
			$display("two_hop_conflict_rows regression: pass");
		else
			$display("two_hop_conflict_rows regression: fail");
		$finish;
	end

endmodule
